[hw/rtl/sor_pkg.sv]
// Shared types, constants and default parameters of the shift-or pattern counter.
`default_nettype none
package sor_pkg;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int MAX_PATTERN_DEF   = 64;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int FUNC_W        = 2;
  localparam int SYMBOL_W      = 8;
  localparam int LEN_W         = 7;
  localparam int MATCH_COUNT_W = 32;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    func_t               func;
    logic [SYMBOL_W-1:0] idx;
  } sor_op_t;

endpackage
`default_nettype wire

[hw/rtl/sor_in_if.sv]
// Input channel: function code and symbol with a valid/ready handshake.
`default_nettype none
interface sor_in_if;
  logic                          valid;
  logic                          ready;
  logic [sor_pkg::FUNC_W-1:0]    func;
  logic [sor_pkg::SYMBOL_W-1:0]  symbol;

  modport source (output valid, func, symbol, input ready);
  modport sink   (input valid, func, symbol, output ready);
endinterface
`default_nettype wire

[hw/rtl/sor_out_if.sv]
// Result channel: match flag, counter and pattern status with a valid/ready handshake.
`default_nettype none
interface sor_out_if;
  logic                               valid;
  logic                               ready;
  logic                               match;
  logic [sor_pkg::MATCH_COUNT_W-1:0]  match_count;
  logic [sor_pkg::LEN_W-1:0]          pattern_length;
  logic                               too_long;

  modport source (output valid, match, match_count, pattern_length, too_long, input ready);
  modport sink   (input valid, match, match_count, pattern_length, too_long, output ready);
endinterface
`default_nettype wire

[hw/rtl/shift_or_pattern_counter_unit.sv]
// A word passes the queue, read stage and result register; its result is held until taken.
// Throughput: one word per cycle while results are taken; one mask RAM read and write per cycle.
// A mask table write is forwarded to a read of the same entry issued in the same cycle.
// Reset clears the match vector, length, flags, counter and per-entry table valid bits at once;
// there is no clearing pass, and a pattern clear likewise resets length, flags and valid bits.
`default_nettype none
module shift_or_pattern_counter_unit #(
  parameter int ALPHABET_SIZE = sor_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_PATTERN   = sor_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH   = sor_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sor_in_if.sink     in_chan,
  sor_out_if.source  out_chan
);

  logic             push_valid, push_ready;
  sor_pkg::sor_op_t push_op;
  logic             pop_valid, pop_ready;
  sor_pkg::sor_op_t pop_op;

  sor_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  sor_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  sor_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_PATTERN   (MAX_PATTERN),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

[hw/rtl/sor_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module sor_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sor_front.sv]
// Front end: accepts words and reduces the symbol to a mask table index.
`default_nettype none
module sor_front #(
  parameter int ALPHABET_SIZE = sor_pkg::ALPHABET_SIZE_DEF
) (
  sor_in_if.sink             in_chan,
  output logic               push_valid,
  input  wire logic          push_ready,
  output sor_pkg::sor_op_t   push_op
);

  localparam int LUT_W = sor_pkg::SYMBOL_W;
  localparam int LUT_N = 1 << sor_pkg::SYMBOL_W;

  // Every byte value reduced modulo the alphabet size, worked out at elaboration.
  function automatic logic [LUT_N*LUT_W-1:0] build_lut();
    logic [LUT_N*LUT_W-1:0] lut;
    lut = '0;
    for (int s = 0; s < LUT_N; s++) begin
      lut[s*LUT_W +: LUT_W] = LUT_W'(s % ALPHABET_SIZE);
    end
    return lut;
  endfunction

  localparam logic [LUT_N*LUT_W-1:0] IDX_LUT = build_lut();

  assign push_valid   = in_chan.valid;
  assign in_chan.ready = push_ready;
  assign push_op.func = sor_pkg::func_t'(in_chan.func);
  assign push_op.idx  = IDX_LUT[{in_chan.symbol, 3'b000} +: LUT_W];

endmodule
`default_nettype wire

[hw/rtl/sor_queue.sv]
// Short queue that decouples the front end from the back end.
`default_nettype none
module sor_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire sor_pkg::sor_op_t  push_op,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output sor_pkg::sor_op_t       pop_op
);

  localparam int DEPTH = sor_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  sor_pkg::sor_op_t entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sor_back.sv]
// Back end: mask table, match vector, pattern length, counter and result register.
`default_nettype none
module sor_back #(
  parameter int ALPHABET_SIZE = sor_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_PATTERN   = sor_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_WIDTH   = sor_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire sor_pkg::sor_op_t  pop_op,
  sor_out_if.source              out_chan
);

  localparam int AW    = $clog2(ALPHABET_SIZE);
  localparam int LW    = sor_pkg::LEN_W;
  localparam int MW    = sor_pkg::MATCH_COUNT_W;
  localparam int EXT_W = COUNT_WIDTH + MW;

  // Read stage capture: the operation plus what is needed to resolve the table word.
  sor_pkg::func_t         ex_func_r;
  logic [AW-1:0]          ex_idx_r;
  logic                   ex_v_r, ex_v_nxt;
  logic                   ex_valid_bit_r;
  logic                   ex_fwd_r;
  logic [MAX_PATTERN-1:0] ex_fwd_data_r;
  logic                   ex_clr_r;

  logic [MAX_PATTERN-1:0] vec_r, vec_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [ALPHABET_SIZE-1:0] tvalid_r, tvalid_nxt;

  logic                   out_v_r, out_v_nxt;
  logic                   out_match_r;
  logic [MW-1:0]          out_count_r;
  logic [LW-1:0]          out_len_r;
  logic                   out_ovf_r;

  logic                   ex_fire, rd_fire;
  logic [AW-1:0]          rd_idx;
  logic [MAX_PATTERN-1:0] rd_data;
  logic [MAX_PATTERN-1:0] mask_eff;
  logic [MAX_PATTERN-1:0] wr_data;
  logic [MAX_PATTERN-1:0] vec_sh;
  logic                   room;
  logic                   wr_en;
  logic                   hit;
  logic [EXT_W-1:0]       cnt_ext;

  assign ex_fire   = ex_v_r && (!out_v_r || out_chan.ready);
  assign rd_fire   = pop_valid && (!ex_v_r || ex_fire);
  assign pop_ready = (!ex_v_r || ex_fire);
  assign rd_idx    = pop_op.idx[AW-1:0];
  assign room      = (len_r < LW'(MAX_PATTERN));

  sor_ram #(
    .WIDTH (MAX_PATTERN),
    .DEPTH (ALPHABET_SIZE)
  ) u_mask_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ex_idx_r),
    .wdata (wr_data),
    .re    (rd_fire),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // A clear or a write by the previous operation overrides what the RAM returned.
  always_comb begin
    if (ex_clr_r) begin
      mask_eff = '1;
    end else if (ex_fwd_r) begin
      mask_eff = ex_fwd_data_r;
    end else if (ex_valid_bit_r) begin
      mask_eff = rd_data;
    end else begin
      mask_eff = '1;
    end
  end

  assign wr_data = mask_eff & ~(MAX_PATTERN'(1) << len_r);

  always_comb begin
    vec_nxt    = vec_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    cnt_nxt    = cnt_r;
    tvalid_nxt = tvalid_r;
    wr_en      = 1'b0;
    hit        = 1'b0;
    vec_sh     = '0;
    if (ex_fire) begin
      unique case (ex_func_r)
        sor_pkg::FUNC_CLEAR: begin
          len_nxt    = '0;
          ovf_nxt    = 1'b0;
          tvalid_nxt = '0;
        end
        sor_pkg::FUNC_PATTERN: begin
          if (room) begin
            wr_en                = 1'b1;
            tvalid_nxt[ex_idx_r] = 1'b1;
            len_nxt              = len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        sor_pkg::FUNC_TEXT: begin
          vec_nxt = (vec_r << 1) | mask_eff;
          vec_sh  = vec_nxt >> (len_r - LW'(1));
          if (len_r != '0 && !ovf_r && !vec_sh[0]) begin
            hit = 1'b1;
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + COUNT_WIDTH'(1);
            end
          end
        end
        sor_pkg::FUNC_RESTART: begin
          vec_nxt = '1;
          cnt_nxt = '0;
        end
        default: begin
          vec_nxt = vec_r;
        end
      endcase
    end
  end

  assign cnt_ext = {{MW{1'b0}}, cnt_nxt};

  always_comb begin
    ex_v_nxt = ex_v_r;
    if (rd_fire) begin
      ex_v_nxt = 1'b1;
    end else if (ex_fire) begin
      ex_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (ex_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      vec_r    <= '1;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
      tvalid_r <= '0;
    end else begin
      ex_v_r   <= ex_v_nxt;
      out_v_r  <= out_v_nxt;
      vec_r    <= vec_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      cnt_r    <= cnt_nxt;
      tvalid_r <= tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      ex_func_r      <= pop_op.func;
      ex_idx_r       <= rd_idx;
      ex_valid_bit_r <= tvalid_r[rd_idx];
      ex_fwd_r       <= ex_fire && wr_en && (ex_idx_r == rd_idx);
      ex_fwd_data_r  <= wr_data;
      ex_clr_r       <= ex_fire && (ex_func_r == sor_pkg::FUNC_CLEAR);
    end
    if (ex_fire) begin
      out_match_r <= hit;
      out_count_r <= cnt_ext[MW-1:0];
      out_len_r   <= len_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.match          = out_match_r;
  assign out_chan.match_count    = out_count_r;
  assign out_chan.pattern_length = out_len_r;
  assign out_chan.too_long       = out_ovf_r;

endmodule
`default_nettype wire
